[hdl/bmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_pkg
// Types, register map, event codes and small helper functions shared by the
// button multi-click detector.
// ----------------------------------------------------------------------------
package bmc_pkg;

   localparam int unsigned CMP_W = 32;

   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CMP_W-1:0] DUR_MAX = 32'h00FF_FFFF;

   localparam logic [8:0] COL_SPLIT_1 = 9'd134;
   localparam logic [8:0] COL_SPLIT_2 = 9'd266;
   localparam logic [8:0] ROW_SPLIT_1 = 9'd100;
   localparam logic [8:0] ROW_SPLIT_2 = 9'd200;

   localparam logic [2:0] REG_DEBOUNCE = 3'd0;
   localparam logic [2:0] REG_REPEAT   = 3'd1;
   localparam logic [2:0] REG_TIMEOUT  = 3'd2;
   localparam logic [2:0] REG_LONG_A   = 3'd3;
   localparam logic [2:0] REG_LONG_B   = 3'd4;
   localparam logic [2:0] REG_LONG_C   = 3'd5;
   localparam logic [2:0] REG_LONG_D   = 3'd6;
   localparam logic [2:0] REG_ACTIVE   = 3'd7;

   localparam logic [3:0] EV_HOLD_BASE       = 4'd0;
   localparam logic [3:0] EV_CLICK_LONG_BASE = 4'd4;
   localparam logic [3:0] EV_SINGLE          = 4'd8;
   localparam logic [3:0] EV_DOUBLE          = 4'd9;
   localparam logic [3:0] EV_TRIPLE          = 4'd10;
   localparam logic [3:0] EV_QUAD            = 4'd11;

   typedef enum logic [3:0] {
      PH_IDLE         = 4'd0,
      PH_PRESS_DEB    = 4'd1,
      PH_HELD         = 4'd2,
      PH_REL_DEB      = 4'd3,
      PH_WAIT_NEXT    = 4'd4,
      PH_NEXT_DEB     = 4'd5,
      PH_NEXT_HELD    = 4'd6,
      PH_NEXT_REL_DEB = 4'd7,
      PH_END_RUN      = 4'd8
   } phase_type;

   typedef struct packed {
      logic [15:0] debounce_ticks;
      logic [15:0] repeat_interval_ticks;
      logic [15:0] press_timeout_ticks;
      logic [23:0] long_a_ticks;
      logic [23:0] long_b_ticks;
      logic [23:0] long_c_ticks;
      logic [23:0] long_d_ticks;
      logic        active_level_high;
   } cfg_type;

   typedef struct packed {
      logic [8:0] touch_y;
      logic [8:0] touch_x;
      logic       pin_raw;
   } item_type;

   typedef struct packed {
      logic        last_of_step;
      logic        run_finished;
      logic [7:0]  clicks_counted;
      logic [23:0] press_duration;
      logic [3:0]  button_number;
      logic [3:0]  event_code;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] code;
   } class_type;

   function automatic logic [3:0] cell_of(logic [8:0] x, logic [8:0] y);
      logic [3:0] col;
      logic [3:0] row3;
      col  = (x < COL_SPLIT_1) ? 4'd0 : ((x < COL_SPLIT_2) ? 4'd1 : 4'd2);
      row3 = (y < ROW_SPLIT_1) ? 4'd0 : ((y < ROW_SPLIT_2) ? 4'd3 : 4'd6);
      return row3 + col + 4'd1;
   endfunction

   function automatic class_type classify(logic [CMP_W-1:0] d, logic [7:0] count,
                                          cfg_type cfg);
      logic       lv;
      logic [3:0] lc;
      class_type  r;
      logic [CMP_W-1:0] a;
      logic [CMP_W-1:0] b;
      logic [CMP_W-1:0] c;
      logic [CMP_W-1:0] e;
      a  = CMP_W'(cfg.long_a_ticks);
      b  = CMP_W'(cfg.long_b_ticks);
      c  = CMP_W'(cfg.long_c_ticks);
      e  = CMP_W'(cfg.long_d_ticks);
      lv = 1'b1;
      lc = 4'd0;
      priority if (d >= a && d < b) begin
         lc = 4'd0;
      end else if (d >= b && d < c) begin
         lc = 4'd1;
      end else if (d >= c && d < e) begin
         lc = 4'd2;
      end else if (d >= e) begin
         lc = 4'd3;
      end else begin
         lv = 1'b0;
      end
      r.valid = 1'b1;
      r.code  = EV_SINGLE;
      unique case (count)
         8'd0: begin
            r.valid = lv;
            r.code  = EV_HOLD_BASE + lc;
         end
         8'd1: r.code = lv ? (EV_CLICK_LONG_BASE + lc) : EV_SINGLE;
         8'd2: r.code = EV_DOUBLE;
         8'd3: r.code = EV_TRIPLE;
         8'd4: r.code = EV_QUAD;
         default: r.valid = 1'b0;
      endcase
      return r;
   endfunction

endpackage

[hdl/button_multi_click_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_multi_click_detector
// Debounces a button pin sampled once per tick, counts clicks and reports
// single to quad clicks, graded long presses, hold repeats and run end.
//
//   Channel  Dir  Handshake              Payload
//   req_*    in   tvalid/tready          tick word: pin level, touch point
//   rsp_*    out  tvalid/tready/tlast    report word, tlast on last of tick
//   csr_*    in   psel/penable/pready    eight registers at byte address 4*i
//
// A tick word is registered, processed when it fires, and its reports land
// in a two-entry output register; one word per cycle is taken unless stalled.
// A tick causing two reports fires only when the output stage is empty after
// that cycle's pop, so behind an earlier two-report tick it waits for both.
// The output stage decides stalls: a word is processed once its reports fit.
// Reset (synchronous, active high) restores config, valid flags and the idle state.
// ----------------------------------------------------------------------------
module button_multi_click_detector
   import bmc_pkg::*;
#(
   parameter int unsigned TIME_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pin_raw [0], touch_x [9:1], touch_y [18:10]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // event_code [3:0], button_number [7:4], press_duration [31:8],
   // clicks_counted [39:32], run_finished [40]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] csr_index;
   logic       csr_write;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       accept;
   logic       fire;

   result_type step_result;
   logic [1:0] step_count;

   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic       v0_ff, v0_in;
   logic       v1_ff, v1_in;
   logic       pop;
   logic [1:0] remain;
   logic [1:0] add;
   logic [2:0] total;
   result_type keep0;
   result_type res_first;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DEBOUNCE: cfg_in.debounce_ticks        = csr_pwdata[15:0];
            REG_REPEAT:   cfg_in.repeat_interval_ticks = csr_pwdata[15:0];
            REG_TIMEOUT:  cfg_in.press_timeout_ticks   = csr_pwdata[15:0];
            REG_LONG_A:   cfg_in.long_a_ticks          = csr_pwdata[23:0];
            REG_LONG_B:   cfg_in.long_b_ticks          = csr_pwdata[23:0];
            REG_LONG_C:   cfg_in.long_c_ticks          = csr_pwdata[23:0];
            REG_LONG_D:   cfg_in.long_d_ticks          = csr_pwdata[23:0];
            REG_ACTIVE:   cfg_in.active_level_high     = csr_pwdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DEBOUNCE: csr_prdata = CSR_DATA_W'(cfg_ff.debounce_ticks);
         REG_REPEAT:   csr_prdata = CSR_DATA_W'(cfg_ff.repeat_interval_ticks);
         REG_TIMEOUT:  csr_prdata = CSR_DATA_W'(cfg_ff.press_timeout_ticks);
         REG_LONG_A:   csr_prdata = CSR_DATA_W'(cfg_ff.long_a_ticks);
         REG_LONG_B:   csr_prdata = CSR_DATA_W'(cfg_ff.long_b_ticks);
         REG_LONG_C:   csr_prdata = CSR_DATA_W'(cfg_ff.long_c_ticks);
         REG_LONG_D:   csr_prdata = CSR_DATA_W'(cfg_ff.long_d_ticks);
         REG_ACTIVE:   csr_prdata = CSR_DATA_W'(cfg_ff.active_level_high);
         default:      csr_prdata = '0;
      endcase
   end

   assign pop    = v0_ff && rsp_tready;
   assign remain = {1'b0, v0_ff} + {1'b0, v1_ff} - {1'b0, pop};
   assign fire   = in_valid_ff && ((3'(remain) + 3'(step_count)) <= 3'd2);
   assign add    = fire ? step_count : 2'd0;
   assign total  = 3'(remain) + 3'(add);

   assign req_tready = !in_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_item_in  = item_type'(req_tdata[18:0]);
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   bmc_step #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_step (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (in_item_ff),
      .cfg          (cfg_ff),
      .result       (step_result),
      .result_count (step_count)
   );

   always_comb begin
      keep0                  = pop ? slot1_ff : slot0_ff;
      res_first              = step_result;
      res_first.last_of_step = (add == 2'd1);
      slot0_in = (remain != 2'd0) ? keep0 : res_first;
      slot1_in = (remain == 2'd2) ? slot1_ff : step_result;
      v0_in    = (total != 3'd0);
      v1_in    = (total == 3'd2);
   end

   assign rsp_tvalid = v0_ff;
   assign rsp_tlast  = slot0_ff.last_of_step;
   assign rsp_tdata  = {7'd0, slot0_ff.run_finished, slot0_ff.clicks_counted,
                        slot0_ff.press_duration, slot0_ff.button_number,
                        slot0_ff.event_code};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks        <= 16'd50;
         cfg_ff.repeat_interval_ticks <= 16'd1000;
         cfg_ff.press_timeout_ticks   <= 16'd400;
         cfg_ff.long_a_ticks          <= 24'd2000;
         cfg_ff.long_b_ticks          <= 24'd5000;
         cfg_ff.long_c_ticks          <= 24'd10000;
         cfg_ff.long_d_ticks          <= 24'd20000;
         cfg_ff.active_level_high     <= 1'b1;
         in_valid_ff                  <= 1'b0;
         v0_ff                        <= 1'b0;
         v1_ff                        <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
         v0_ff       <= v0_in;
         v1_ff       <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      slot0_ff   <= slot0_in;
      slot1_ff   <= slot1_in;
   end

   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> v0_ff)
      else $error("second output slot valid without first");

   a_slot_advance: assert property (@(posedge clock) disable iff (reset)
      (v0_ff && v1_ff && rsp_tready) |=> v0_ff)
      else $error("queued report lost on pop");

   a_pair_queued: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> v1_ff)
      else $error("non-last report without its partner queued");

endmodule

[hdl/bmc_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_step
// Click state machine with its tick counters; processes one tick word per
// fire and presents up to two identical reports for that tick.
// ----------------------------------------------------------------------------
module bmc_step
   import bmc_pkg::*;
#(
   parameter int unsigned TIME_WIDTH = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result,
   output logic [1:0] result_count
);

   phase_type             phase_ff, phase_in;
   logic                  press_pend_ff, press_pend_in;
   logic                  rel_pend_ff, rel_pend_in;
   logic                  prev_pin_ff, prev_pin_in;
   logic [TIME_WIDTH-1:0] tip_ff, tip_in;
   logic [TIME_WIDTH-1:0] tsp_ff, tsp_in;
   logic [TIME_WIDTH-1:0] tsr_ff, tsr_in;
   logic [7:0]            clicks_ff, clicks_in;

   logic                  act;
   logic                  press_pend;
   logic                  rel_pend;
   logic                  rel_cond;
   logic [TIME_WIDTH-1:0] tip, tsp, tsr;
   logic [CMP_W-1:0]      tip_w, tsp_w, tsr_w;
   logic                  deb_tip, deb_tsp, timeout_hit, repeat_due;
   logic                  emit_a, emit_b, finished;
   logic [7:0]            clicks_inc;
   class_type             cls;

   assign act        = (item.pin_raw == cfg.active_level_high);
   assign press_pend = (item.pin_raw != prev_pin_ff) ? act : press_pend_ff;
   assign rel_pend   = (item.pin_raw != prev_pin_ff) ? !act : rel_pend_ff;
   assign rel_cond   = rel_pend || !act;

   assign tip = (tip_ff == '1) ? tip_ff : tip_ff + TIME_WIDTH'(1);
   assign tsp = (tsp_ff == '1) ? tsp_ff : tsp_ff + TIME_WIDTH'(1);
   assign tsr = (tsr_ff == '1) ? tsr_ff : tsr_ff + TIME_WIDTH'(1);

   assign tip_w = CMP_W'(tip);
   assign tsp_w = CMP_W'(tsp);
   assign tsr_w = CMP_W'(tsr);

   assign deb_tip     = tip_w >= CMP_W'(cfg.debounce_ticks);
   assign deb_tsp     = tsp_w >= CMP_W'(cfg.debounce_ticks);
   assign timeout_hit = tip_w >= CMP_W'(cfg.press_timeout_ticks);
   assign repeat_due  = tsr_w >= CMP_W'(cfg.repeat_interval_ticks);
   assign clicks_inc  = (clicks_ff == 8'hFF) ? clicks_ff : clicks_ff + 8'd1;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE:         if (press_pend) phase_in = PH_PRESS_DEB;
         PH_PRESS_DEB:    if (deb_tsp) phase_in = act ? PH_HELD : PH_END_RUN;
         PH_HELD:         if (rel_cond) phase_in = PH_REL_DEB;
         PH_REL_DEB,
         PH_NEXT_REL_DEB: if (deb_tip) phase_in = PH_WAIT_NEXT;
         PH_WAIT_NEXT: begin
            priority if (press_pend) phase_in = PH_NEXT_DEB;
            else if (timeout_hit) phase_in = PH_END_RUN;
         end
         PH_NEXT_DEB:     if (deb_tip) phase_in = act ? PH_NEXT_HELD : PH_WAIT_NEXT;
         PH_NEXT_HELD:    if (rel_cond) phase_in = PH_NEXT_REL_DEB;
         default:         phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      press_pend_in = press_pend;
      rel_pend_in   = rel_pend;
      prev_pin_in   = item.pin_raw;
      tip_in        = tip;
      tsp_in        = tsp;
      tsr_in        = tsr;
      clicks_in     = clicks_ff;
      emit_a        = 1'b0;
      emit_b        = 1'b0;
      finished      = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (press_pend) begin
               press_pend_in = 1'b0;
               tip_in        = '0;
               tsp_in        = '0;
               tsr_in        = '0;
            end
         end
         PH_PRESS_DEB, PH_REL_DEB, PH_NEXT_DEB, PH_NEXT_REL_DEB: begin
         end
         PH_HELD: begin
            if (rel_cond) begin
               rel_pend_in = 1'b0;
               clicks_in   = clicks_inc;
               emit_a      = 1'b1;
               tip_in      = '0;
            end
            if (repeat_due) begin
               tsr_in = '0;
               emit_b = 1'b1;
            end
         end
         PH_WAIT_NEXT: begin
            priority if (press_pend) begin
               press_pend_in = 1'b0;
               tip_in        = '0;
            end else if (timeout_hit) begin
               emit_a   = 1'b1;
               finished = 1'b1;
            end
         end
         PH_NEXT_HELD: begin
            if (rel_cond) begin
               rel_pend_in = 1'b0;
               clicks_in   = clicks_inc;
               emit_a      = 1'b1;
               tip_in      = '0;
            end
         end
         default: clicks_in = 8'd0;
      endcase
   end

   assign cls = classify(tsp_w, clicks_in, cfg);

   always_comb begin
      result.event_code     = cls.code;
      result.button_number  = cell_of(item.touch_x, item.touch_y);
      result.press_duration = (tsp_w > DUR_MAX) ? DUR_MAX[23:0] : tsp_w[23:0];
      result.clicks_counted = clicks_in;
      result.run_finished   = finished;
      result.last_of_step   = 1'b1;
      result_count = {1'b0, emit_a && cls.valid} + {1'b0, emit_b && cls.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         press_pend_ff <= 1'b0;
         rel_pend_ff   <= 1'b0;
         prev_pin_ff   <= 1'b0;
         tip_ff        <= '0;
         tsp_ff        <= '0;
         tsr_ff        <= '0;
         clicks_ff     <= 8'd0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         press_pend_ff <= press_pend_in;
         rel_pend_ff   <= rel_pend_in;
         prev_pin_ff   <= prev_pin_in;
         tip_ff        <= tip_in;
         tsp_ff        <= tsp_in;
         tsr_ff        <= tsr_in;
         clicks_ff     <= clicks_in;
      end
   end

   a_idle_no_clicks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> clicks_ff == 8'd0)
      else $error("click count not cleared in idle phase");

   a_first_hold_no_clicks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HELD |-> clicks_ff == 8'd0)
      else $error("clicks counted before first release");

endmodule

[bench/bmc_report_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmc_report_checker
// Watches the tick, report and register channels of the button multi-click
// detector, keeps its own model of the click state machine, and compares
// every report word with the oldest predicted one.
// ----------------------------------------------------------------------------
module bmc_report_checker
   import bmc_pkg::*;
#(
   parameter int unsigned TIME_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int unsigned           mismatch_count,
   output int unsigned           pending_reports
);

   localparam logic [31:0] TICK_MAX = 32'((64'd1 << TIME_WIDTH) - 64'd1);

   cfg_type               cfg;
   phase_type             ph;
   logic                  press_pend;
   logic                  release_pend;
   logic                  prev_pin;
   logic [31:0]           in_phase;
   logic [31:0]           since_press;
   logic [31:0]           since_repeat;
   logic [7:0]            clicks;
   result_type            tick_reports [2];
   int                    tick_report_count;
   result_type            expected_reports [$];
   result_type            want;
   logic [RSP_DATA_W-1:0] want_word;
   int unsigned           errors = 0;
   int unsigned           backlog = 0;

   assign mismatch_count  = errors;
   assign pending_reports = backlog;

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v >= TICK_MAX) ? TICK_MAX : v + 32'd1;
   endfunction

   // Event code for a duration and click count, or -1 when nothing is raised.
   function automatic int report_code(logic [31:0] d, logic [7:0] n);
      int grade;
      grade = -1;
      if (d >= cfg.long_a_ticks && d < cfg.long_b_ticks) begin
         grade = 0;
      end else if (d >= cfg.long_b_ticks && d < cfg.long_c_ticks) begin
         grade = 1;
      end else if (d >= cfg.long_c_ticks && d < cfg.long_d_ticks) begin
         grade = 2;
      end else if (d >= cfg.long_d_ticks) begin
         grade = 3;
      end
      case (n)
         8'd0: return (grade >= 0) ? int'(EV_HOLD_BASE) + grade : -1;
         8'd1: return (grade >= 0) ? int'(EV_CLICK_LONG_BASE) + grade : int'(EV_SINGLE);
         8'd2: return int'(EV_DOUBLE);
         8'd3: return int'(EV_TRIPLE);
         8'd4: return int'(EV_QUAD);
         default: return -1;
      endcase
   endfunction

   task automatic raise_report(input logic [3:0] grid_pos, input logic finished);
      int         code;
      result_type rec;
      code = report_code(since_press, clicks);
      if (code >= 0) begin
         rec.event_code     = 4'(code);
         rec.button_number  = grid_pos;
         rec.press_duration = (since_press > DUR_MAX) ? DUR_MAX[23:0] : since_press[23:0];
         rec.clicks_counted = clicks;
         rec.run_finished   = finished;
         rec.last_of_step   = 1'b0;
         tick_reports[tick_report_count] = rec;
         tick_report_count++;
      end
   endtask

   task automatic predict_tick(input item_type word);
      logic       act;
      logic [3:0] grid_pos;
      int         col;
      int         row;
      act = (word.pin_raw == cfg.active_level_high);
      col = (word.touch_x < COL_SPLIT_1) ? 0 : ((word.touch_x < COL_SPLIT_2) ? 1 : 2);
      row = (word.touch_y < ROW_SPLIT_1) ? 0 : ((word.touch_y < ROW_SPLIT_2) ? 1 : 2);
      grid_pos = 4'(row * 3 + col + 1);
      tick_report_count = 0;

      in_phase     = bump(in_phase);
      since_press  = bump(since_press);
      since_repeat = bump(since_repeat);

      if (word.pin_raw != prev_pin) begin
         press_pend   = act;
         release_pend = !act;
      end
      prev_pin = word.pin_raw;

      case (ph)
         PH_IDLE: begin
            if (press_pend) begin
               press_pend   = 1'b0;
               in_phase     = '0;
               since_press  = '0;
               since_repeat = '0;
               ph           = PH_PRESS_DEB;
            end
         end
         PH_PRESS_DEB: begin
            if (since_press >= cfg.debounce_ticks) ph = act ? PH_HELD : PH_END_RUN;
         end
         PH_HELD: begin
            if (release_pend || !act) begin
               release_pend = 1'b0;
               clicks       = (clicks == 8'hFF) ? clicks : clicks + 8'd1;
               raise_report(grid_pos, 1'b0);
               in_phase     = '0;
               ph           = PH_REL_DEB;
            end
            if (since_repeat >= cfg.repeat_interval_ticks) begin
               since_repeat = '0;
               raise_report(grid_pos, 1'b0);
            end
         end
         PH_REL_DEB, PH_NEXT_REL_DEB: begin
            if (in_phase >= cfg.debounce_ticks) ph = PH_WAIT_NEXT;
         end
         PH_WAIT_NEXT: begin
            if (press_pend) begin
               press_pend = 1'b0;
               in_phase   = '0;
               ph         = PH_NEXT_DEB;
            end else if (in_phase >= cfg.press_timeout_ticks) begin
               raise_report(grid_pos, 1'b1);
               ph = PH_END_RUN;
            end
         end
         PH_NEXT_DEB: begin
            if (in_phase >= cfg.debounce_ticks) ph = act ? PH_NEXT_HELD : PH_WAIT_NEXT;
         end
         PH_NEXT_HELD: begin
            if (release_pend || !act) begin
               release_pend = 1'b0;
               clicks       = (clicks == 8'hFF) ? clicks : clicks + 8'd1;
               raise_report(grid_pos, 1'b0);
               in_phase     = '0;
               ph           = PH_NEXT_REL_DEB;
            end
         end
         default: begin
            clicks = '0;
            ph     = PH_IDLE;
         end
      endcase

      if (tick_report_count > 0) tick_reports[tick_report_count - 1].last_of_step = 1'b1;
      for (int k = 0; k < tick_report_count; k++) expected_reports.push_back(tick_reports[k]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.debounce_ticks        = 16'd50;
         cfg.repeat_interval_ticks = 16'd1000;
         cfg.press_timeout_ticks   = 16'd400;
         cfg.long_a_ticks          = 24'd2000;
         cfg.long_b_ticks          = 24'd5000;
         cfg.long_c_ticks          = 24'd10000;
         cfg.long_d_ticks          = 24'd20000;
         cfg.active_level_high     = 1'b1;
         ph           = PH_IDLE;
         press_pend   = 1'b0;
         release_pend = 1'b0;
         prev_pin     = 1'b0;
         in_phase     = '0;
         since_press  = '0;
         since_repeat = '0;
         clicks       = '0;
         expected_reports.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_DEBOUNCE: cfg.debounce_ticks        = csr_pwdata[15:0];
               REG_REPEAT:   cfg.repeat_interval_ticks = csr_pwdata[15:0];
               REG_TIMEOUT:  cfg.press_timeout_ticks   = csr_pwdata[15:0];
               REG_LONG_A:   cfg.long_a_ticks          = csr_pwdata[23:0];
               REG_LONG_B:   cfg.long_b_ticks          = csr_pwdata[23:0];
               REG_LONG_C:   cfg.long_c_ticks          = csr_pwdata[23:0];
               REG_LONG_D:   cfg.long_d_ticks          = csr_pwdata[23:0];
               REG_ACTIVE:   cfg.active_level_high     = csr_pwdata[0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) predict_tick(item_type'(req_tdata[18:0]));

         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t ns: unexpected report word %h last %b", $time, rsp_tdata,
                        rsp_tlast);
               errors++;
            end else begin
               want = expected_reports.pop_front();
               want_word = '0;
               want_word[40:0] = {want.run_finished, want.clicks_counted,
                                  want.press_duration, want.button_number,
                                  want.event_code};
               if (rsp_tdata !== want_word || rsp_tlast !== want.last_of_step) begin
                  $display("%0t ns: report mismatch, expected code %0d button %0d dur %0d",
                           $time, want.event_code, want.button_number,
                           want.press_duration);
                  $display("   clicks %0d finished %0b last %0b pad 0",
                           want.clicks_counted, want.run_finished, want.last_of_step);
                  $display("   actual code %0d button %0d dur %0d clicks %0d",
                           rsp_tdata[3:0], rsp_tdata[7:4], rsp_tdata[31:8],
                           rsp_tdata[39:32]);
                  $display("   finished %0b last %0b pad %h", rsp_tdata[40], rsp_tlast,
                           rsp_tdata[RSP_DATA_W-1:41]);
                  errors++;
               end
            end
         end
      end
      backlog <= expected_reports.size();
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the button multi-click detector with tick words shaped as press and
// release gestures under a series of register settings, with random gaps on
// the tick side and random stalls on the report side. A checker beside the
// block predicts and compares the reports; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import bmc_pkg::*;

   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_LIMIT   = 20000;
   localparam logic [24:0] DIRECTED_PINS = 25'b0110011_000000_111111_000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int unsigned           mismatch_count;
   int unsigned           pending_reports;

   cfg_type stim_cfg;
   int      quiet_ticks = 0;

   button_multi_click_detector DUT (.*);
   bmc_report_checker checker_inst (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #16_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin : ready_pattern
      int r;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            rsp_tready <= 1'b0;
            repeat ((r < 17) ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8))
            @(posedge clock);
      end
   end

   function automatic cfg_type make_cfg(int deb, int rep, int tmo, int a, int b, int c,
                                        int d, int act);
      cfg_type s;
      s.debounce_ticks        = 16'(deb);
      s.repeat_interval_ticks = 16'(rep);
      s.press_timeout_ticks   = 16'(tmo);
      s.long_a_ticks          = 24'(a);
      s.long_b_ticks          = 24'(b);
      s.long_c_ticks          = 24'(c);
      s.long_d_ticks          = 24'(d);
      s.active_level_high     = 1'(act);
      return s;
   endfunction

   function automatic cfg_type random_cfg();
      int a;
      int b;
      int c;
      int d;
      if ($urandom_range(0, 3) == 0) begin
         a = $urandom_range(0, 20);
         b = $urandom_range(0, 20);
         c = $urandom_range(0, 20);
         d = $urandom_range(0, 20);
      end else begin
         a = $urandom_range(0, 5);
         b = a + $urandom_range(0, 6);
         c = b + $urandom_range(0, 6);
         d = c + $urandom_range(0, 6);
      end
      return make_cfg($urandom_range(0, 3), $urandom_range(0, 9), $urandom_range(0, 6),
                      a, b, c, d, $urandom_range(0, 1));
   endfunction

   function automatic logic [8:0] boundary_coord(int k);
      case (k)
         0: return 9'd0;
         1: return ROW_SPLIT_1 - 9'd1;
         2: return ROW_SPLIT_1;
         3: return COL_SPLIT_1 - 9'd1;
         4: return COL_SPLIT_1;
         5: return ROW_SPLIT_2 - 9'd1;
         6: return ROW_SPLIT_2;
         7: return COL_SPLIT_2 - 9'd1;
         8: return COL_SPLIT_2;
         default: return 9'd511;
      endcase
   endfunction

   function automatic logic [8:0] pick_coord();
      if ($urandom_range(0, 1) == 1) return 9'($urandom_range(0, 511));
      return boundary_coord($urandom_range(0, 9));
   endfunction

   function automatic int next_gap();
      int r;
      if (quiet_ticks > 0) begin
         quiet_ticks--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         quiet_ticks = $urandom_range(20, 80);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic int reach(logic [23:0] t, int s);
      return (t <= 24'd60 && int'(t) + 4 > s) ? int'(t) + 4 : s;
   endfunction

   task automatic send_tick(input logic pin, input logic [8:0] x, input logic [8:0] y);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({y, x, pin});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic tick(input logic pin);
      send_tick(pin, pick_coord(), pick_coord());
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_reports != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input cfg_type s);
      stim_cfg = s;
      csr_write(REG_DEBOUNCE, 32'(s.debounce_ticks));
      csr_write(REG_REPEAT, 32'(s.repeat_interval_ticks));
      csr_write(REG_TIMEOUT, 32'(s.press_timeout_ticks));
      csr_write(REG_LONG_A, 32'(s.long_a_ticks));
      csr_write(REG_LONG_B, 32'(s.long_b_ticks));
      csr_write(REG_LONG_C, 32'(s.long_c_ticks));
      csr_write(REG_LONG_D, 32'(s.long_d_ticks));
      csr_write(REG_ACTIVE, 32'(s.active_level_high));
   endtask

   // One run of clicks: held presses, releases, optional bounce, and a final
   // quiet stretch past short debounce and timeout. Some runs are plain noise.
   task automatic play_gesture();
      logic pressed;
      int   deb_c;
      int   tmo_c;
      int   span;
      int   clicks;
      int   hold;
      int   rel;
      int   r;
      pressed = stim_cfg.active_level_high;
      deb_c = (stim_cfg.debounce_ticks > 16'd16) ? 16 : int'(stim_cfg.debounce_ticks);
      tmo_c = (stim_cfg.press_timeout_ticks > 16'd30) ? 30 : int'(stim_cfg.press_timeout_ticks);
      span = reach(stim_cfg.long_a_ticks, 8);
      span = reach(stim_cfg.long_b_ticks, span);
      span = reach(stim_cfg.long_c_ticks, span);
      span = reach(stim_cfg.long_d_ticks, span);
      if ($urandom_range(0, 9) == 0) wait_drain();
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 16)) tick(1'($urandom_range(0, 1)));
         return;
      end
      r = $urandom_range(0, 19);
      clicks = (r < 6) ? 1 : (r < 11) ? 2 : (r < 15) ? 3 : (r < 18) ? 4 : $urandom_range(5, 7);
      for (int k = 0; k < clicks; k++) begin
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               tick(pressed);
               tick(!pressed);
            end
         end
         if (k == 0) hold = deb_c + $urandom_range(1, span);
         else hold = ($urandom_range(0, 7) == 0) ? 1 : deb_c + $urandom_range(1, 4);
         repeat (hold) tick(pressed);
         if (k < clicks - 1) rel = $urandom_range(1, deb_c + tmo_c + 2);
         else rel = deb_c + tmo_c + $urandom_range(2, 6);
         repeat (rel) tick(!pressed);
      end
   endtask

   initial begin : stimulus
      int guard;
      stim_cfg = make_cfg(50, 1000, 400, 2000, 5000, 10000, 20000, 1);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      apply_setting(make_cfg(0, 3, 4, 2, 4, 6, 8, 1));
      for (int k = 0; k < 25; k++) begin
         send_tick(DIRECTED_PINS[24 - k], boundary_coord(k % 10),
                   boundary_coord((k * 3 + 5) % 10));
      end

      wait_drain();
      apply_setting(make_cfg(2, 5, 6, 5, 10, 15, 20, 0));
      repeat (2) play_gesture();

      wait_drain();
      apply_setting(make_cfg(1, 0, 0, 0, 3, 3, 7, 1));
      repeat (2) play_gesture();

      // Enough quick clicks in one run to saturate the click count.
      wait_drain();
      apply_setting(make_cfg(0, 65535, 65535, 'hFF_FFFF, 'hFF_FFFF, 'hFF_FFFF, 'hFF_FFFF, 1));
      repeat (260) begin
         tick(1'b1);
         tick(1'b1);
         tick(1'b0);
         tick(1'b0);
      end

      wait_drain();
      apply_setting(make_cfg(65535, 1, 1, 1, 2, 4, 16, 0));
      repeat (1) play_gesture();

      wait_drain();
      apply_setting(make_cfg(1, 1, 3, 9, 6, 12, 3, 1));
      repeat (2) play_gesture();

      for (int p = 0; p < 2; p++) begin
         wait_drain();
         apply_setting(random_cfg());
         repeat (2) play_gesture();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      guard = 0;
      while (pending_reports != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_reports == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
